FILE: rtl/tnp_pkg.sv
// ----------------------------------------------------------------------------
// tnp_pkg
// Shared types, byte codes and sizes for the Telnet IAC negotiation parser.
// ----------------------------------------------------------------------------
package tnp_pkg;

    // default width of the byte position counter
    localparam int OFFSET_BITS_DEF = 16;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 3;
    localparam int REASON_W = 2;
    localparam int OUT_OFS_W = 16;
    localparam int LEN_W    = 16;
    localparam int CNT_W    = 17;

    // reset value of the payload limit register
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd1024;

    // payload counter saturation value
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // result queue depth; input is held off while fewer than four slots are free
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_HOLD  = 4;

    // Telnet byte codes
    localparam logic [BYTE_W-1:0] BYTE_IAC  = 8'd255;
    localparam logic [BYTE_W-1:0] BYTE_SB   = 8'd250;
    localparam logic [BYTE_W-1:0] BYTE_SE   = 8'd240;
    localparam logic [BYTE_W-1:0] BYTE_WILL = 8'd251;
    localparam logic [BYTE_W-1:0] BYTE_DONT = 8'd254;

    // verb low bits minus this give the event kind (WILL -> 1 ... DONT -> 4)
    localparam logic [KIND_W-1:0] VERB_KIND_BIAS = 3'd2;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SUB_END = 3'd5;

    // close reasons
    localparam logic [REASON_W-1:0] REASON_SE    = 2'd0;
    localparam logic [REASON_W-1:0] REASON_TRUNC = 2'd1;
    localparam logic [REASON_W-1:0] REASON_BUF   = 2'd2;

    // parser phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_IAC,
        PH_VERB,
        PH_SUB,
        PH_SUBIAC
    } t_phase;

    // one result item
    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [BYTE_W-1:0]    option;
        logic [BYTE_W-1:0]    payload;
        logic [REASON_W-1:0]  reason;
        logic [OUT_OFS_W-1:0] offset;
        logic                 run_last;
    } t_result;

    // results produced by one byte: up to two
    typedef struct packed {
        logic [1:0] n;
        t_result    res0;
        t_result    res1;
    } t_push;

    // append one result to a push group
    function automatic t_push push_add(t_push p, t_result r);
        if (p.n == 2'd0) begin
            p.res0 = r;
        end else begin
            p.res1 = r;
        end
        p.n = p.n + 2'd1;
        return p;
    endfunction

endpackage

FILE: rtl/tnp_in_if.sv
// ----------------------------------------------------------------------------
// tnp_in_if
// Input byte channel: one buffer byte and its end-of-buffer flag per request.
// ----------------------------------------------------------------------------
interface tnp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

FILE: rtl/tnp_out_if.sv
// ----------------------------------------------------------------------------
// tnp_out_if
// Event channel: one parser event per request.
// ----------------------------------------------------------------------------
interface tnp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [7:0]  option_code;
    logic [7:0]  payload_byte;
    logic [1:0]  close_reason;
    logic [15:0] start_offset;
    logic        run_last;

    modport source (
        output valid, output event_kind, output option_code, output payload_byte,
        output close_reason, output start_offset, output run_last, input ready
    );
    modport sink (
        input valid, input event_kind, input option_code, input payload_byte,
        input close_reason, input start_offset, input run_last, output ready
    );
endinterface

FILE: rtl/tnp_cfg_if.sv
// ----------------------------------------------------------------------------
// tnp_cfg_if
// Configuration write channel for the payload length limit.
// ----------------------------------------------------------------------------
interface tnp_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_subneg_len;

    modport source (output valid, output max_subneg_len, input ready);
    modport sink   (input valid, input max_subneg_len, output ready);
endinterface

FILE: rtl/telnet_iac_negotiation_parser.sv
// ----------------------------------------------------------------------------
// telnet_iac_negotiation_parser
// Telnet IAC scanner: negotiation events and subnegotiation payload streams.
// ----------------------------------------------------------------------------
// Takes one buffer byte per clock cycle as long as the event side keeps up.
// A byte is registered, parsed in the following cycle, and its results (zero,
// one or two) enter an eight-entry result queue. The first event of a byte is
// therefore valid once the queue has stored it, behind any earlier events.
// The queue hands out one event per cycle while the event side is ready.
// A byte that yields two events therefore needs two output transfers. Input
// ready drops whenever fewer than four queue slots are free. The payload
// length limit is written through the configuration channel, which is always
// ready; write it only while the parser is idle.
module telnet_iac_negotiation_parser #(
    parameter int OFFSET_BITS = tnp_pkg::OFFSET_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tnp_in_if.sink       i_in,
    tnp_cfg_if.sink      i_cfg,
    tnp_out_if.source    o_out
);

    localparam int CNT_W = $clog2(tnp_pkg::QUEUE_DEPTH + 1);

    tnp_pkg::t_push     push;
    tnp_pkg::t_result   head;
    logic [CNT_W-1:0]   q_count;
    logic               accept;

    // input handshake: room for this byte and the one in flight
    assign i_in.ready  = (q_count <= CNT_W'(tnp_pkg::QUEUE_DEPTH - tnp_pkg::QUEUE_HOLD));
    assign accept      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    tnp_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_byte    (i_in.data_byte),
        .i_last    (i_in.buffer_end),
        .i_cfg_wr  (i_cfg.valid),
        .i_cfg_len (i_cfg.max_subneg_len),
        .o_push    (push)
    );

    tnp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_out.ready),
        .o_valid (o_out.valid),
        .o_head  (head),
        .o_count (q_count)
    );

    // event fields
    assign o_out.event_kind   = head.kind;
    assign o_out.option_code  = head.option;
    assign o_out.payload_byte = head.payload;
    assign o_out.close_reason = head.reason;
    assign o_out.start_offset = head.offset;
    assign o_out.run_last     = head.run_last;

endmodule

FILE: rtl/tnp_core.sv
// ----------------------------------------------------------------------------
// tnp_core
// Input register, phase machine and payload counter; emits up to two results
// per byte into the result queue.
// ----------------------------------------------------------------------------
module tnp_core #(
    parameter int OFFSET_BITS = tnp_pkg::OFFSET_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic [tnp_pkg::BYTE_W-1:0]        i_byte,
    input  logic                              i_last,
    input  logic                              i_cfg_wr,
    input  logic [tnp_pkg::LEN_W-1:0]         i_cfg_len,
    output tnp_pkg::t_push                    o_push
);

    // input register
    logic                        r_vld;
    logic [tnp_pkg::BYTE_W-1:0]  r_byte;
    logic                        r_last;

    // parser state
    tnp_pkg::t_phase             r_phase, n_phase;
    logic [tnp_pkg::BYTE_W-1:0]  r_verb, n_verb;
    logic [tnp_pkg::BYTE_W-1:0]  r_opt, n_opt;
    logic [OFFSET_BITS-1:0]      r_start, n_start;
    logic [OFFSET_BITS-1:0]      r_pos, n_pos;
    logic [tnp_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [tnp_pkg::LEN_W-1:0]   r_max;

    logic [tnp_pkg::CNT_W-1:0]   cnt_a, cnt_b, max_ext;
    logic [tnp_pkg::OUT_OFS_W-1:0] start_out;
    tnp_pkg::t_push              push;

    // low bits of the event start, or the start zero-extended, for the 16-bit output field
    generate
        if (OFFSET_BITS >= tnp_pkg::OUT_OFS_W) begin : g_ofs_cut
            assign start_out = r_start[tnp_pkg::OUT_OFS_W-1:0];
        end else begin : g_ofs_ext
            assign start_out = {{(tnp_pkg::OUT_OFS_W-OFFSET_BITS){1'b0}}, r_start};
        end
    endgenerate

    // saturating payload counts after one and two more bytes
    assign max_ext = {1'b0, r_max};
    assign cnt_a   = (r_cnt == tnp_pkg::CNT_MAX) ? r_cnt : r_cnt + 1'b1;
    assign cnt_b   = (cnt_a == tnp_pkg::CNT_MAX) ? cnt_a : cnt_a + 1'b1;

    // result builder
    function automatic tnp_pkg::t_result mk(
        logic [tnp_pkg::KIND_W-1:0]    kind,
        logic [tnp_pkg::BYTE_W-1:0]    opt,
        logic [tnp_pkg::BYTE_W-1:0]    pay,
        logic [tnp_pkg::REASON_W-1:0]  reason,
        logic [tnp_pkg::OUT_OFS_W-1:0] ofs
    );
        tnp_pkg::t_result r;
        r.kind     = kind;
        r.option   = opt;
        r.payload  = pay;
        r.reason   = reason;
        r.offset   = ofs;
        r.run_last = 1'b0;
        return r;
    endfunction

    // phase machine: next state and results for the registered byte
    always_comb begin
        n_phase = r_phase;
        n_verb  = r_verb;
        n_opt   = r_opt;
        n_start = r_start;
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        push    = '0;

        if (r_vld) begin
            case (r_phase)
                tnp_pkg::PH_IAC: begin
                    if (r_last || r_byte == tnp_pkg::BYTE_IAC ||
                        (r_byte != tnp_pkg::BYTE_SB &&
                         (r_byte < tnp_pkg::BYTE_WILL || r_byte > tnp_pkg::BYTE_DONT))) begin
                        n_phase = tnp_pkg::PH_IDLE;
                    end else begin
                        n_verb  = r_byte;
                        n_phase = tnp_pkg::PH_VERB;
                    end
                end
                tnp_pkg::PH_VERB: begin
                    n_opt = r_byte;
                    if (r_verb == tnp_pkg::BYTE_SB) begin
                        n_cnt = '0;
                        if (r_last) begin
                            push = tnp_pkg::push_add(push, mk(tnp_pkg::KIND_SUB_END, r_byte,
                                '0, tnp_pkg::REASON_BUF, start_out));
                            n_phase = tnp_pkg::PH_IDLE;
                        end else begin
                            n_phase = tnp_pkg::PH_SUB;
                        end
                    end else begin
                        push = tnp_pkg::push_add(push, mk(r_verb[2:0] - tnp_pkg::VERB_KIND_BIAS,
                            r_byte, '0, tnp_pkg::REASON_SE, start_out));
                        n_phase = tnp_pkg::PH_IDLE;
                    end
                end
                tnp_pkg::PH_SUB: begin
                    if (r_last) begin
                        push = tnp_pkg::push_add(push, mk(tnp_pkg::KIND_SUB_END, r_opt,
                            '0, tnp_pkg::REASON_BUF, start_out));
                        n_phase = tnp_pkg::PH_IDLE;
                    end else if (r_byte == tnp_pkg::BYTE_IAC) begin
                        n_phase = tnp_pkg::PH_SUBIAC;
                    end else begin
                        n_cnt = cnt_a;
                        if (cnt_a > max_ext) begin
                            push = tnp_pkg::push_add(push, mk(tnp_pkg::KIND_SUB_END, r_opt,
                                '0, tnp_pkg::REASON_TRUNC, start_out));
                            n_phase = tnp_pkg::PH_IDLE;
                        end else if (r_cnt < max_ext) begin
                            push = tnp_pkg::push_add(push, mk(tnp_pkg::KIND_PAYLOAD, r_opt,
                                r_byte, tnp_pkg::REASON_SE, start_out));
                        end
                    end
                end
                tnp_pkg::PH_SUBIAC: begin
                    if (r_byte == tnp_pkg::BYTE_SE) begin
                        push = tnp_pkg::push_add(push, mk(tnp_pkg::KIND_SUB_END, r_opt,
                            '0, tnp_pkg::REASON_SE, start_out));
                        n_phase = tnp_pkg::PH_IDLE;
                    end else if (r_byte == tnp_pkg::BYTE_IAC) begin
                        // escaped 255: never truncates by itself
                        n_cnt   = cnt_a;
                        n_phase = tnp_pkg::PH_SUB;
                        if (r_cnt < max_ext) begin
                            push = tnp_pkg::push_add(push, mk(tnp_pkg::KIND_PAYLOAD, r_opt,
                                tnp_pkg::BYTE_IAC, tnp_pkg::REASON_SE, start_out));
                        end
                        if (r_last) begin
                            push = tnp_pkg::push_add(push, mk(tnp_pkg::KIND_SUB_END, r_opt,
                                '0, tnp_pkg::REASON_BUF, start_out));
                            n_phase = tnp_pkg::PH_IDLE;
                        end
                    end else begin
                        // lone IAC becomes a 255 byte, then this byte is payload
                        n_cnt   = cnt_a;
                        n_phase = tnp_pkg::PH_SUB;
                        if (cnt_a > max_ext) begin
                            push = tnp_pkg::push_add(push, mk(tnp_pkg::KIND_SUB_END, r_opt,
                                '0, tnp_pkg::REASON_TRUNC, start_out));
                            n_phase = tnp_pkg::PH_IDLE;
                        end else begin
                            if (r_cnt < max_ext) begin
                                push = tnp_pkg::push_add(push, mk(tnp_pkg::KIND_PAYLOAD, r_opt,
                                    tnp_pkg::BYTE_IAC, tnp_pkg::REASON_SE, start_out));
                            end
                            if (r_last) begin
                                push = tnp_pkg::push_add(push, mk(tnp_pkg::KIND_SUB_END, r_opt,
                                    '0, tnp_pkg::REASON_BUF, start_out));
                                n_phase = tnp_pkg::PH_IDLE;
                            end else begin
                                n_cnt = cnt_b;
                                if (cnt_b > max_ext) begin
                                    push = tnp_pkg::push_add(push, mk(tnp_pkg::KIND_SUB_END,
                                        r_opt, '0, tnp_pkg::REASON_TRUNC, start_out));
                                    n_phase = tnp_pkg::PH_IDLE;
                                end else if (cnt_a < max_ext) begin
                                    push = tnp_pkg::push_add(push, mk(tnp_pkg::KIND_PAYLOAD,
                                        r_opt, r_byte, tnp_pkg::REASON_SE, start_out));
                                end
                            end
                        end
                    end
                end
                default: begin
                    n_phase = tnp_pkg::PH_IDLE;
                    if (r_byte == tnp_pkg::BYTE_IAC && !r_last) begin
                        n_start = r_pos;
                        n_phase = tnp_pkg::PH_IAC;
                    end
                end
            endcase

            // mark the last result of this byte
            if (push.n == 2'd1) begin
                push.res0.run_last = 1'b1;
            end else if (push.n == 2'd2) begin
                push.res1.run_last = 1'b1;
            end

            // buffer end clears all sequence state; position saturates
            if (r_last) begin
                n_phase = tnp_pkg::PH_IDLE;
                n_verb  = '0;
                n_opt   = '0;
                n_start = '0;
                n_pos   = '0;
                n_cnt   = '0;
            end else if (r_pos != {OFFSET_BITS{1'b1}}) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    assign o_push = push;

    // input register payload
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_byte <= i_byte;
            r_last <= i_last;
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_phase <= tnp_pkg::PH_IDLE;
            r_verb  <= '0;
            r_opt   <= '0;
            r_start <= '0;
            r_pos   <= '0;
            r_cnt   <= '0;
            r_max   <= tnp_pkg::MAX_LEN_RESET;
        end else begin
            r_vld   <= i_accept;
            r_phase <= n_phase;
            r_verb  <= n_verb;
            r_opt   <= n_opt;
            r_start <= n_start;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
            if (i_cfg_wr) begin
                r_max <= i_cfg_len;
            end
        end
    end

    // payload events only come out of an open subnegotiation
    a_payload_in_sub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.n != 2'd0 && push.res0.kind == tnp_pkg::KIND_PAYLOAD) |->
        (r_phase == tnp_pkg::PH_SUB || r_phase == tnp_pkg::PH_SUBIAC))
        else $error("payload event outside subnegotiation");

    // a buffer's final byte leaves the parser idle at position zero
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && r_last) |=> (r_phase == tnp_pkg::PH_IDLE && r_pos == '0 && r_cnt == '0))
        else $error("state not cleared after buffer end");

endmodule

FILE: rtl/tnp_queue.sv
// ----------------------------------------------------------------------------
// tnp_queue
// Result queue: takes up to two results per cycle, hands out one per request.
// ----------------------------------------------------------------------------
module tnp_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tnp_pkg::t_push        i_push,
    input  logic                  i_pop,
    output logic                  o_valid,
    output tnp_pkg::t_result      o_head,
    output logic [$clog2(tnp_pkg::QUEUE_DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = $clog2(tnp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(tnp_pkg::QUEUE_DEPTH + 1);

    tnp_pkg::t_result   mem [tnp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [PTR_W-1:0]   wr_next;
    logic               pop;

    assign pop     = i_pop && (r_count != '0);
    assign wr_next = r_wr + 1'b1;

    // pointer and fill count update
    always_comb begin
        n_wr    = r_wr + PTR_W'(i_push.n);
        n_rd    = pop ? r_rd + 1'b1 : r_rd;
        n_count = r_count + CNT_W'(i_push.n) - CNT_W'(pop);
    end

    // storage writes
    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            mem[r_wr] <= i_push.res0;
        end
        if (i_push.n == 2'd2) begin
            mem[wr_next] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = mem[r_rd];
    assign o_count = r_count;

    // fill count stays within the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(tnp_pkg::QUEUE_DEPTH))
        else $error("result queue count out of range");

    // a push always finds room
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.n != 2'd0) |->
        ({1'b0, r_count} + {{(CNT_W-1){1'b0}}, i_push.n} <= (CNT_W+1)'(tnp_pkg::QUEUE_DEPTH)))
        else $error("result queue overflow");

endmodule
